FILE: design/positional_array_insert_delete_core_assert.svh
// Assertion macros of the positional array RTL.
// Depends on nothing; files that assert include it inside a module body.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define PAID_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define PAID_ASSERT(lbl, prop, msg) \
  `PAID_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/paid_pkg.sv
// Package of the positional array block: word type, command and status codes, states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package paid_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_CREATED = 3'd1,
    ST_EXISTS      = 3'd2,
    ST_BAD_POS     = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_INS,
    S_INSV,
    S_DEL0,
    S_DSH,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: design/positional_array_insert_delete_core.sv
// Top level of the positional array: command sequencer, length and existence state.
// Depends on paid_pkg, paid_mem and positional_array_insert_delete_core_assert.svh.
//
// Usage: requests enter on the in channel (cmd_i, position_i, value_i) under
// in_valid_i / in_ready_o, and every request returns exactly one result on the
// out channel (status_o, data_out_o, length_o) under out_valid_o / out_ready_i.
// Requests are worked one at a time; the elements live in a memory with a
// registered read, and each shift step writes one element and, but for the
// last step, reads the next. A create and any error go straight to the
// response; a read waits for the memory data; an insert moves the elements
// from the last one down to the target position up by one and then writes the
// value (an append writes it at once); a delete reads the element and moves
// the ones behind it down by one. The sequencer turns idle, ready for the next
// request, as the result is loaded into the output register.
// The result sits in an output register: a new request is accepted while the
// previous result still waits, and a finished request holds in its response
// step for as long as the receiver stalls.
// Reset clears the existence flag, the length and the handshake state; the
// element memory is not cleared, since only positions below the length are read.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_insert_delete_core #(
  parameter int DEPTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      cmd_i,
  input  wire logic [3:0]      position_i,
  input  wire paid_pkg::word_t value_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           status_o,
  output paid_pkg::word_t      data_out_o,
  output logic [3:0]           length_o
);
  import paid_pkg::*;

  // Count width holds DEPTH itself; compare width also holds length+1 and a position.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = ((CW > 4) ? CW : 4) + 1;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             exists_q, exists_d;
  logic [3:0]       pos_q, pos_d;
  word_t            val_q, val_d;
  logic [AW-1:0]    rp_q, rp_d;
  status_e          res_status_q, res_status_d;
  word_t            res_data_q, res_data_d;

  logic             out_valid_q;
  status_e          out_status_q;
  word_t            out_data_q;
  logic [3:0]       out_len_q;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  word_t            wr_data;
  word_t            rd_data;

  logic             acc;
  logic             load_out;
  cmd_e             cmd_in;
  status_e          chk;
  logic [PW-1:0]    pos_w, cnt_w, posq_w, rp_w, depth_w;
  logic             app, ins_last, del_last, dsh_last;

  assign cmd_in  = cmd_e'(cmd_i);
  assign pos_w   = PW'(position_i);
  assign cnt_w   = PW'(count_q);
  assign posq_w  = PW'(pos_q);
  assign rp_w    = PW'(rp_q);
  assign depth_w = PW'(DEPTH);

  // A request is taken only while the sequencer is idle.
  assign in_ready_o = (state_q == S_IDLE);

  assign acc      = in_valid_i && in_ready_o;
  assign load_out = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // An insert right behind the last element needs no shifting.
  assign app      = (pos_w == cnt_w + PW'(1));
  // Insert shifting ends once the element at the target position has moved up.
  assign ins_last = (rp_w + PW'(1) == posq_w);
  // Deleting the last element needs no shift, else shifting ends once it moved down.
  assign del_last = (posq_w == cnt_w);
  assign dsh_last = (rp_w + PW'(1) == cnt_w);

  // Checks of the incoming request against the current state. A bad position
  // is reported before a full array.
  always_comb begin
    chk = ST_OK;
    case (cmd_in)
      CMD_CREATE: begin
        if (exists_q) chk = ST_EXISTS;
      end
      CMD_INSERT: begin
        if (!exists_q) begin
          chk = ST_NOT_CREATED;
        end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          chk = ST_BAD_POS;
        end else if (cnt_w == depth_w) begin
          chk = ST_FULL;
        end
      end
      default: begin
        if (!exists_q) begin
          chk = ST_NOT_CREATED;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          chk = ST_BAD_POS;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (chk != ST_OK) begin
            state_d = S_RESP;
          end else begin
            case (cmd_in)
              CMD_READ:   state_d = S_RDWAIT;
              CMD_INSERT: state_d = app ? S_INSV : S_INS;
              CMD_DELETE: state_d = S_DEL0;
              default:    state_d = S_RESP;
            endcase
          end
        end
      end
      S_RDWAIT: state_d = S_RESP;
      S_INS:    state_d = ins_last ? S_INSV : S_INS;
      S_INSV:   state_d = S_RESP;
      S_DEL0:   state_d = del_last ? S_RESP : S_DSH;
      S_DSH:    state_d = dsh_last ? S_RESP : S_DSH;
      S_RESP:   state_d = load_out ? S_IDLE : S_RESP;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory accesses and register updates.
  always_comb begin
    count_d      = count_q;
    exists_d     = exists_q;
    pos_d        = pos_q;
    val_d        = val_q;
    rp_d         = rp_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = val_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          pos_d        = position_i;
          val_d        = value_i;
          res_status_d = chk;
          res_data_d   = '0;
          if (chk == ST_OK) begin
            case (cmd_in)
              CMD_CREATE: begin
                exists_d = 1'b1;
                count_d  = '0;
              end
              CMD_INSERT: begin
                if (!app) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(cnt_w - PW'(1));
                  rp_d    = AW'(cnt_w - PW'(1));
                end
              end
              default: begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_w - PW'(1));
              end
            endcase
          end
        end
      end
      S_RDWAIT: begin
        res_data_d = rd_data;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(rp_w + PW'(1));
        wr_data = rd_data;
        if (!ins_last) begin
          rd_en   = 1'b1;
          rd_addr = AW'(rp_w - PW'(1));
          rp_d    = AW'(rp_w - PW'(1));
        end
      end
      S_INSV: begin
        wr_en   = 1'b1;
        wr_addr = AW'(posq_w - PW'(1));
        wr_data = val_q;
        count_d = CW'(cnt_w + PW'(1));
      end
      S_DEL0: begin
        res_data_d = rd_data;
        if (del_last) begin
          count_d = CW'(cnt_w - PW'(1));
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(posq_w);
          rp_d    = AW'(posq_w);
        end
      end
      S_DSH: begin
        wr_en   = 1'b1;
        wr_addr = AW'(rp_w - PW'(1));
        wr_data = rd_data;
        if (dsh_last) begin
          count_d = CW'(cnt_w - PW'(1));
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(rp_w + PW'(1));
          rp_d    = AW'(rp_w + PW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      exists_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      exists_q <= exists_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    val_q        <= val_d;
    rp_q         <= rp_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_len_q    <= cnt_w[3:0];
    end
  end

  paid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign length_o    = out_len_q;

`include "positional_array_insert_delete_core_assert.svh"

  // The length only changes on the step that leads into the response.
  `PAID_ASSERT(a_count_moves_into_resp,
               (count_q != $past(count_q)) |-> (state_q == S_RESP),
               "length changed outside the response step")

  // The memory is never written while idle or while holding a result.
  `PAID_ASSERT(a_no_write_idle,
               wr_en |-> ((state_q != S_IDLE) && (state_q != S_RESP)),
               "memory written outside a shift step")

  // A finished result waits while the output register is full and stalled.
  `PAID_ASSERT(a_resp_holds,
               ((state_q == S_RESP) && out_valid_q && !out_ready_i) |=> (state_q == S_RESP),
               "result left the response step under a stall")

  // An array that does not exist holds no elements, and the length stays in range.
  `PAID_ASSERT(a_count_range,
               (exists_q || (count_q == '0)) && (cnt_w <= depth_w),
               "length out of range")

endmodule

`default_nettype wire

FILE: design/paid_mem.sv
// Element store of the positional array: one write and one registered read per cycle.
// Depends on paid_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module paid_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire                logic    clk_i,
  input  wire                logic    rd_en_i,
  input  wire                logic [AW-1:0] rd_addr_i,
  input  wire                logic    wr_en_i,
  input  wire                logic [AW-1:0] wr_addr_i,
  input  wire                paid_pkg::word_t wr_data_i,
  output paid_pkg::word_t    rd_data_o
);
  import paid_pkg::*;

  word_t mem_q [DEPTH];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
